/* design/fnvnh_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fnvnh_pkg
// Shared types, constants and the byte absorb step of the FNV-1a 64 hasher.
// ----------------------------------------------------------------------------
package fnvnh_pkg;

  localparam int unsigned HASH_W             = 64;
  localparam int unsigned BYTE_W             = 8;
  localparam int unsigned MAX_WORD_BYTES     = 8;
  localparam int unsigned WORD_BYTES_DEFAULT = 8;
  localparam int unsigned BYTE_CNT_W         = $clog2(MAX_WORD_BYTES + 1);
  localparam int unsigned QUEUE_DEPTH        = 2;

  localparam logic [HASH_W-1:0] OFFSET_BASIS = 64'hCBF29CE484222325;
  // prime = 2^40 + 0x1B3
  localparam int unsigned       PRIME_SHIFT  = 40;
  localparam logic [8:0]        PRIME_LO     = 9'h1B3;

  typedef enum logic [1:0] {
    OP_RAW  = 2'd0,
    OP_NAME = 2'd1,
    OP_WORD = 2'd2
  } opcode_e;

  typedef struct packed {
    logic [HASH_W-1:0]     data;
    logic [BYTE_CNT_W-1:0] nbytes;
    logic                  first;
    logic                  last;
  } fnvnh_entry_t;

  // One FNV-1a step: xor the byte in, multiply by the prime mod 2^64.
  function automatic logic [HASH_W-1:0] fnv_absorb(input logic [HASH_W-1:0] h,
                                                   input logic [BYTE_W-1:0] b);
    logic [HASH_W-1:0] x;
    logic [HASH_W-1:0] lo;
    x  = h ^ {{(HASH_W-BYTE_W){1'b0}}, b};
    lo = x * {{(HASH_W-9){1'b0}}, PRIME_LO};
    fnv_absorb = (x << PRIME_SHIFT) + lo;
  endfunction

endpackage
`default_nettype wire

/* design/fnvnh_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fnvnh_front
// Accepts input items, normalizes name bytes and sets the byte count.
// ----------------------------------------------------------------------------
module fnvnh_front #(
  parameter int unsigned WORD_BYTES = fnvnh_pkg::WORD_BYTES_DEFAULT
) (
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [1:0]            opcode_i,
  input  wire logic [63:0]           data_value_i,
  input  wire logic                  first_item_i,
  input  wire logic                  last_item_i,
  input  wire logic                  q_full_i,
  output logic                       q_push_o,
  output fnvnh_pkg::fnvnh_entry_t    q_entry_o
);
  import fnvnh_pkg::*;

  logic [BYTE_W-1:0] in_byte;
  logic [BYTE_W-1:0] norm_byte;

  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;
  assign in_byte    = data_value_i[BYTE_W-1:0];

  always_comb begin
    if (in_byte inside {[8'h41:8'h5A]}) begin
      norm_byte = in_byte + 8'h20;
    end else if (in_byte == 8'h5C) begin
      norm_byte = 8'h2F;
    end else begin
      norm_byte = in_byte;
    end
  end

  always_comb begin
    q_entry_o.first = first_item_i;
    q_entry_o.last  = last_item_i;
    case (opcode_e'(opcode_i))
      OP_RAW: begin
        q_entry_o.data   = {{(HASH_W-BYTE_W){1'b0}}, in_byte};
        q_entry_o.nbytes = BYTE_CNT_W'(1);
      end
      OP_NAME: begin
        q_entry_o.data   = {{(HASH_W-BYTE_W){1'b0}}, norm_byte};
        q_entry_o.nbytes = BYTE_CNT_W'(1);
      end
      OP_WORD: begin
        q_entry_o.data   = data_value_i;
        q_entry_o.nbytes = BYTE_CNT_W'(WORD_BYTES);
      end
      default: begin
        // undefined opcode absorbs nothing
        q_entry_o.data   = '0;
        q_entry_o.nbytes = '0;
      end
    endcase
  end

endmodule
`default_nettype wire

/* design/fnvnh_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fnvnh_queue
// Short FIFO between the front and the absorb engine.
// ----------------------------------------------------------------------------
module fnvnh_queue (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    push_i,
  input  wire fnvnh_pkg::fnvnh_entry_t entry_i,
  output logic                         full_o,
  input  wire logic                    pop_i,
  output logic                         valid_o,
  output fnvnh_pkg::fnvnh_entry_t      entry_o
);
  import fnvnh_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

  fnvnh_entry_t      slots_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign entry_o = slots_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule
`default_nettype wire

/* design/fnvnh_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fnvnh_back
// Absorb engine: one byte per cycle into the running hash, result register.
// ----------------------------------------------------------------------------
module fnvnh_back (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    q_valid_i,
  input  wire fnvnh_pkg::fnvnh_entry_t q_entry_i,
  output logic                         q_pop_o,
  output logic                         out_valid_o,
  input  wire logic                    out_stall_i,
  output logic [63:0]                  hash_result_o
);
  import fnvnh_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_ABSORB = 3'b010,
    ST_EMIT   = 3'b100
  } back_state_e;

  back_state_e           state_q, state_d;
  logic [HASH_W-1:0]     hash_q, hash_d;
  logic [HASH_W-1:0]     data_q, data_d;
  logic [BYTE_CNT_W-1:0] cnt_q, cnt_d;
  logic                  last_q, last_d;
  logic                  out_valid_q, out_valid_d;
  logic [HASH_W-1:0]     out_hash_q, out_hash_d;
  logic                  out_free;

  assign out_free      = !out_valid_q || !out_stall_i;
  assign out_valid_o   = out_valid_q;
  assign hash_result_o = out_hash_q;

  always_comb begin
    state_d     = state_q;
    hash_d      = hash_q;
    data_d      = data_q;
    cnt_d       = cnt_q;
    last_d      = last_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_hash_d  = out_hash_q;
    q_pop_o     = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          hash_d  = q_entry_i.first ? OFFSET_BASIS : hash_q;
          data_d  = q_entry_i.data;
          cnt_d   = q_entry_i.nbytes;
          last_d  = q_entry_i.last;
          if (q_entry_i.nbytes != '0) begin
            state_d = ST_ABSORB;
          end else if (q_entry_i.last) begin
            state_d = ST_EMIT;
          end
        end
      end
      ST_ABSORB: begin
        hash_d = fnv_absorb(hash_q, data_q[BYTE_W-1:0]);
        data_d = data_q >> BYTE_W;
        cnt_d  = cnt_q - BYTE_CNT_W'(1);
        if (cnt_q == BYTE_CNT_W'(1)) begin
          state_d = last_q ? ST_EMIT : ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          // zero maps to one on output only
          out_hash_d  = (hash_q == '0) ? HASH_W'(1) : hash_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      hash_q      <= OFFSET_BASIS;
      cnt_q       <= '0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      hash_q      <= hash_d;
      cnt_q       <= cnt_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q     <= data_d;
    out_hash_q <= out_hash_d;
  end

endmodule
`default_nettype wire

/* design/fnv1a64_normalizing_hasher_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fnv1a64_normalizing_hasher_unit
// Streaming FNV-1a 64 hasher for raw bytes, normalized name bytes and words.
// ----------------------------------------------------------------------------
// Input channel: in_valid_i / in_stall_o with opcode_i, data_value_i,
// first_item_i and last_item_i. An item is taken when valid is high and
// stall is low; first_item_i restarts from the offset basis.
// Output channel: out_valid_o / out_stall_i with hash_result_o, one result
// for each item marked last_item_i.
// Items pass through a two-entry queue into an absorb engine that runs one
// byte per cycle through a single constant multiply. The engine takes an
// item from the queue while idle, then absorbs its N bytes, N being its byte
// count (1 for byte items, WORD_BYTES for word items, 0 for an undefined
// opcode), and for an item marked last then loads the result register.
// While the receiver stalls, the result register holds; the engine waits
// with its next result and the queue keeps taking items until full.
// Reset empties the queue, clears out_valid_o and loads the offset basis.
// ----------------------------------------------------------------------------
module fnv1a64_normalizing_hasher_unit #(
  parameter int unsigned WORD_BYTES = fnvnh_pkg::WORD_BYTES_DEFAULT
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  opcode_i,
  input  wire logic [63:0] data_value_i,
  input  wire logic        first_item_i,
  input  wire logic        last_item_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [63:0]      hash_result_o
);
  import fnvnh_pkg::*;

  logic         q_full;
  logic         q_push;
  logic         q_pop;
  logic         q_valid;
  fnvnh_entry_t push_entry;
  fnvnh_entry_t head_entry;

  fnvnh_front #(
    .WORD_BYTES(WORD_BYTES)
  ) u_front (
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .opcode_i    (opcode_i),
    .data_value_i(data_value_i),
    .first_item_i(first_item_i),
    .last_item_i (last_item_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_entry_o   (push_entry)
  );

  fnvnh_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .entry_i(push_entry),
    .full_o (q_full),
    .pop_i  (q_pop),
    .valid_o(q_valid),
    .entry_o(head_entry)
  );

  fnvnh_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .q_entry_i    (head_entry),
    .q_pop_o      (q_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .hash_result_o(hash_result_o)
  );

  a_nonzero_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (hash_result_o != '0))
    else $error("zero hash result emitted");

  a_pop_needs_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid)
    else $error("engine popped an empty queue");

  a_push_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_push && !q_pop) |=> q_valid)
    else $error("pushed item missing from queue");

  a_stall_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_full |-> (in_stall_o && !q_push))
    else $error("item accepted into a full queue");

endmodule
`default_nettype wire

/* verif/fnv1a64_normalizing_hasher_unit_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fnv1a64_normalizing_hasher_unit_test
// Drives hash streams of raw, name, word and undefined items into the hasher
// with random gaps and output stalls. A scoreboard keeps its own running
// FNV-1a 64 state and checks every emitted hash in order.
// ----------------------------------------------------------------------------

class hash_scoreboard;
  localparam logic [63:0] FNV_PRIME = 64'h0000_0100_0000_01B3;

  logic [63:0] running_hash;
  logic [63:0] expected_hashes[$];
  int          mismatches;
  int          hashes_checked;
  int          op_counts[4];

  function new();
    running_hash   = fnvnh_pkg::OFFSET_BASIS;
    mismatches     = 0;
    hashes_checked = 0;
    foreach (op_counts[i]) op_counts[i] = 0;
  endfunction

  function logic [63:0] mix_byte(logic [63:0] h, logic [7:0] b);
    return (h ^ {56'b0, b}) * FNV_PRIME;
  endfunction

  // Upper case folds to lower case, backslash to slash, the rest passes.
  function logic [7:0] fold_name_byte(logic [7:0] b);
    if (b >= 8'h41 && b <= 8'h5A) return b + 8'h20;
    if (b == 8'h5C) return 8'h2F;
    return b;
  endfunction

  function void note_item(logic [1:0] op, logic [63:0] data, logic first, logic last);
    logic [63:0] h;
    if (first) running_hash = fnvnh_pkg::OFFSET_BASIS;
    h = running_hash;
    case (op)
      fnvnh_pkg::OP_RAW:  h = mix_byte(h, data[7:0]);
      fnvnh_pkg::OP_NAME: h = mix_byte(h, fold_name_byte(data[7:0]));
      fnvnh_pkg::OP_WORD: begin
        for (int i = 0; i < fnvnh_pkg::WORD_BYTES_DEFAULT; i++) h = mix_byte(h, data[8*i +: 8]);
      end
      default: ;
    endcase
    running_hash = h;
    op_counts[op]++;
    if (last) expected_hashes.push_back((h == 64'd0) ? 64'd1 : h);
  endfunction

  function void check_result(logic [63:0] got);
    logic [63:0] want;
    if (expected_hashes.size() == 0) begin
      $display("%t: hash %h arrived with none expected (expected none, actual %h)",
               $time, got, got);
      mismatches++;
      return;
    end
    want = expected_hashes.pop_front();
    hashes_checked++;
    if (got !== want) begin
      $display("%t: hash_result mismatch: expected %h, actual %h", $time, want, got);
      mismatches++;
    end
  endfunction

  function int pending();
    return expected_hashes.size();
  endfunction
endclass

module fnv1a64_normalizing_hasher_unit_test;
  import fnvnh_pkg::*;

  localparam logic [1:0] OP_UNDEF     = 2'd3;
  localparam int         IDLE_LIMIT   = 2000;
  localparam int         RANDOM_ITEMS = 1850;
  localparam int         DRAIN_CYCLES = 16;

  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        in_valid_i   = 1'b0;
  logic        in_stall_o;
  logic [1:0]  opcode_i     = OP_RAW;
  logic [63:0] data_value_i = 64'd0;
  logic        first_item_i = 1'b0;
  logic        last_item_i  = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i  = 1'b0;
  logic [63:0] hash_result_o;

  hash_scoreboard sb = new();
  bit quiet      = 1'b0;
  int items_sent = 0;
  int idle_cycles = 0;
  int stall_left  = 0;
  bit stall_now   = 1'b0;

  fnv1a64_normalizing_hasher_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .opcode_i      (opcode_i),
    .data_value_i  (data_value_i),
    .first_item_i  (first_item_i),
    .last_item_i   (last_item_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .hash_result_o (hash_result_o)
  );

  always #2 clk_i = ~clk_i;

  // Mostly short idle runs, now and then a long one.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      if (quiet) begin
        stall_now  = 1'b0;
        stall_left = 1;
      end else begin
        stall_now  = ($urandom_range(0, 99) < 35);
        stall_left = stall_now ? idle_len() : $urandom_range(1, 16);
      end
    end
    stall_left--;
    out_stall_i <= stall_now;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(hash_result_o);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%t: no item moved for %0d cycles", $time, IDLE_LIMIT);
      $display("fnv1a64_normalizing_hasher_unit test failed");
      $finish;
    end
  end

  // Called at a rising edge; returns at the edge that accepts the item.
  task automatic drive_item(logic [1:0] op, logic [63:0] data, bit first, bit last);
    int gap;
    gap = (quiet || $urandom_range(0, 99) < 55) ? 0 : idle_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    opcode_i     <= op;
    data_value_i <= data;
    first_item_i <= first;
    last_item_i  <= last;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_item(op, data, first, last);
    items_sent++;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  function automatic logic [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [1:0] pick_op();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return OP_RAW;
    if (r < 70) return OP_NAME;
    if (r < 96) return OP_WORD;
    return OP_UNDEF;
  endfunction

  function automatic logic [63:0] pick_data(logic [1:0] op);
    logic [7:0] b;
    int r;
    r = $urandom_range(0, 99);
    if (op == OP_WORD) begin
      if (r < 5) return 64'd0;
      if (r < 10) return '1;
      return rand_word();
    end
    if (op == OP_NAME) begin
      if (r < 40) b = 8'h41 + 8'($urandom_range(0, 25));
      else if (r < 50) b = 8'h5C;
      else if (r < 60) b = 8'h80 + 8'($urandom_range(0, 127));
      else b = 8'($urandom_range(0, 255));
    end else begin
      b = 8'($urandom_range(0, 255));
    end
    // Junk in the unused upper bits half the time.
    if ($urandom_range(0, 1)) return (rand_word() << 8) | {56'd0, b};
    return {56'd0, b};
  endfunction

  // Well-formed message: first on the opening item, last on the closing one.
  // A broken message scatters the flags at random.
  task automatic send_message(int len, bit broken);
    logic [1:0] op;
    bit first, last;
    for (int i = 0; i < len; i++) begin
      op    = pick_op();
      first = broken ? ($urandom_range(0, 3) == 0) : (i == 0);
      last  = broken ? ($urandom_range(0, 3) == 0) : (i == len - 1);
      drive_item(op, pick_data(op), first, last);
    end
  endtask

  task automatic random_phase(int target);
    int len;
    while (items_sent < target) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
      send_message(len, $urandom_range(0, 9) == 0);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Single-item hashes at the field extremes and around the fold ranges.
    drive_item(OP_RAW,  64'h0000_0000_0000_0000, 1, 1);
    drive_item(OP_RAW,  64'hFFFF_FFFF_FFFF_FFFF, 1, 1);
    drive_item(OP_RAW,  64'hFFFF_FFFF_FFFF_FF00, 1, 1);
    drive_item(OP_NAME, 64'h0000_0000_0000_0041, 1, 1);
    drive_item(OP_NAME, 64'h0000_0000_0000_005A, 1, 1);
    drive_item(OP_NAME, 64'h0000_0000_0000_0040, 1, 1);
    drive_item(OP_NAME, 64'h0000_0000_0000_005B, 1, 1);
    drive_item(OP_NAME, 64'h0000_0000_0000_005C, 1, 1);
    drive_item(OP_NAME, 64'h0000_0000_0000_0080, 1, 1);
    drive_item(OP_NAME, 64'hDEAD_BEEF_0000_0061, 1, 1);
    drive_item(OP_NAME, 64'hFFFF_FFFF_FFFF_FFFF, 1, 1);
    drive_item(OP_WORD, 64'h0000_0000_0000_0000, 1, 1);
    drive_item(OP_WORD, 64'hFFFF_FFFF_FFFF_FFFF, 1, 1);
    drive_item(OP_WORD, 64'h0123_4567_89AB_CDEF, 1, 1);
    drive_item(OP_UNDEF, 64'h1234_5678_9ABC_DEF0, 1, 1);
    // Prefix, folded name and word in one stream.
    drive_item(OP_RAW,  64'h0000_0000_0000_0076, 1, 0);
    drive_item(OP_RAW,  64'h0000_0000_0000_003A, 0, 0);
    drive_item(OP_NAME, 64'h0000_0000_0000_0046, 0, 0);
    drive_item(OP_NAME, 64'h0000_0000_0000_005C, 0, 0);
    drive_item(OP_WORD, 64'h8000_0000_0000_0001, 0, 1);
    // Continue without a restart; undefined opcode only re-emits the state.
    drive_item(OP_UNDEF, 64'hFFFF_FFFF_FFFF_FFFF, 0, 1);
    drive_item(OP_RAW,  64'h0000_0000_0000_007F, 0, 0);
    drive_item(OP_WORD, 64'h0000_0000_0000_0001, 0, 1);
    drive_item(OP_WORD, rand_word(), 1, 1);

    random_phase(items_sent + 900);
    wait_drained();
    quiet = 1'b1;
    random_phase(items_sent + 300);
    quiet = 1'b0;
    random_phase(items_sent + RANDOM_ITEMS - 1200);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (sb.pending() != 0) begin
      $display("%t: %0d hashes never arrived (expected %h, actual none)",
               $time, sb.pending(), sb.expected_hashes[0]);
      sb.mismatches += sb.pending();
    end
    $display("Sent %0d items: raw %0d, name %0d, word %0d, undefined opcode %0d.",
             items_sent, sb.op_counts[OP_RAW], sb.op_counts[OP_NAME],
             sb.op_counts[OP_WORD], sb.op_counts[OP_UNDEF]);
    $display("Checked %0d hashes under random gaps, output stalls and a no-idle stretch.",
             sb.hashes_checked);
    if (sb.mismatches == 0) begin
      $display("fnv1a64_normalizing_hasher_unit test passed");
    end else begin
      $display("fnv1a64_normalizing_hasher_unit test failed");
    end
    $finish;
  end

endmodule
